[src/uhv_pkg.sv]
package uhv_pkg;

  localparam int HdrBytes = 64;
  localparam int CrcSpan  = 60;
  localparam int CfgIdxW  = 3;

  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [31:0] MAGIC     = 32'h3155_5445;  // magic bytes 0..3 read little-endian
  localparam logic [31:0] MAX_PKG_RST = 32'h0010_0000;
  localparam logic [31:0] HDR_LEN32 = 32'd64;

  typedef enum logic [3:0] {
    ST_OK      = 4'd0,
    ST_MAGIC   = 4'd1,
    ST_HDRLEN  = 4'd2,
    ST_HDRCRC  = 4'd3,
    ST_FLAGS   = 4'd4,
    ST_ALGO    = 4'd5,
    ST_KEY     = 4'd6,
    ST_HW      = 4'd7,
    ST_LAYOUT  = 4'd8,
    ST_BOOT    = 4'd9,
    ST_VERSION = 4'd10,
    ST_BASE    = 4'd11,
    ST_LENGTH  = 4'd12
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HW_REV   = 3'd0,
    REG_LAYOUT   = 3'd1,
    REG_BOOT     = 3'd2,
    REG_RUN_VER  = 3'd3,
    REG_REQ_FLAG = 3'd4,
    REG_MAX_PKG  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] hardware_revision;
    logic [7:0]  layout_code;
    logic [7:0]  boot_level;
    logic [31:0] running_version;
    logic [15:0] required_flags;
    logic [31:0] max_package_bytes;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    hardware_revision: 16'd0,
    layout_code:       8'd0,
    boot_level:        8'd0,
    running_version:   32'd0,
    required_flags:    16'd0,
    max_package_bytes: MAX_PKG_RST
  };

  // one complete header, with the configuration-independent checks done
  typedef struct packed {
    logic        magic_ok;
    logic        hdrlen_ok;
    logic        crc_ok;
    logic        algo_ok;
    logic        key_ok;
    logic        base_ok;
    logic [15:0] flags;
    logic [15:0] hw_rev;
    logic [7:0]  layout;
    logic [7:0]  req_boot;
    logic [31:0] target_version;
    logic [31:0] payload_length;
    logic [31:0] payload_checksum;
    logic [63:0] nonce_upper;
    logic [63:0] nonce_lower;
    logic [31:0] package_bytes;
  } hdr_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[src/uhv_front.sv]
module uhv_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         header_byte,
  input  logic               first_byte,
  input  logic [31:0]        package_bytes,
  output logic               push,
  output uhv_pkg::hdr_rec_t  rec
);

  logic [5:0]  pos_r, pos_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [5:0]  pos;
  logic [31:0] crc_base, crc_upd;
  logic [7:0]  hdr_r [63];
  logic [7:0]  hb [64];
  logic        tail_nz;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ uhv_pkg::CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  assign pos      = first_byte ? 6'd0 : pos_r;
  assign crc_base = (pos == 6'd0) ? uhv_pkg::CRC_INIT : crc_r;
  assign crc_upd  = crc_byte(crc_base, header_byte);

  always_comb begin
    pos_nxt = pos_r;
    crc_nxt = crc_r;
    if (accept) begin
      pos_nxt = pos + 6'd1;
      if (pos < 6'(uhv_pkg::CrcSpan)) begin
        crc_nxt = crc_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      crc_r <= uhv_pkg::CRC_INIT;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
    end
  end

  // shift line: after 63 bytes, hdr_r[62] holds offset 0 and hdr_r[0] offset 62
  always_ff @(posedge clk) begin
    if (accept) begin
      hdr_r[0] <= header_byte;
      for (int i = 1; i < 63; i++) begin
        hdr_r[i] <= hdr_r[i-1];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 63; k++) begin
      hb[k] = hdr_r[62-k];
    end
    hb[63] = header_byte;
  end

  always_comb begin
    tail_nz = 1'b0;
    for (int k = 52; k < 60; k++) begin
      tail_nz = tail_nz | (hb[k] != 8'd0);
    end
  end

  assign push = accept && (pos == 6'(uhv_pkg::HdrBytes - 1));

  always_comb begin
    rec.magic_ok  = {hb[3], hb[2], hb[1], hb[0]} == uhv_pkg::MAGIC;
    rec.hdrlen_ok = {hb[5], hb[4]} == uhv_pkg::HDR_LEN32[15:0];
    rec.crc_ok    = (crc_r ^ uhv_pkg::CRC_INIT) == {hb[63], hb[62], hb[61], hb[60]};
    rec.algo_ok   = {hb[11], hb[10], hb[9], hb[8]} == 32'd1;
    rec.key_ok    = {hb[15], hb[14], hb[13], hb[12]} == 32'd1;
    rec.base_ok   = ({hb[47], hb[46], hb[45], hb[44]} == 32'd0) && !tail_nz;
    rec.flags     = {hb[7], hb[6]};
    rec.hw_rev    = {hb[49], hb[48]};
    rec.layout    = hb[50];
    rec.req_boot  = hb[51];
    rec.target_version   = {hb[43], hb[42], hb[41], hb[40]};
    rec.payload_length   = {hb[35], hb[34], hb[33], hb[32]};
    rec.payload_checksum = {hb[39], hb[38], hb[37], hb[36]};
    rec.nonce_upper = {hb[23], hb[22], hb[21], hb[20], hb[19], hb[18], hb[17], hb[16]};
    rec.nonce_lower = {hb[31], hb[30], hb[29], hb[28], hb[27], hb[26], hb[25], hb[24]};
    rec.package_bytes = package_bytes;
  end

endmodule

[src/uhv_queue.sv]
module uhv_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  uhv_pkg::hdr_rec_t  push_rec,
  input  logic               pop,
  output uhv_pkg::hdr_rec_t  head_rec,
  output uhv_pkg::q_stat_t   stat
);

  uhv_pkg::hdr_rec_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  assign head_rec   = mem_r[rd_ptr_r];
  assign stat.full  = cnt_r == 2'd2;
  assign stat.empty = cnt_r == 2'd0;

endmodule

[src/uhv_back.sv]
module uhv_back (
  input  logic               clk,
  input  logic               rst_n,
  input  uhv_pkg::cfg_t      cfg,
  input  logic               head_valid,
  input  uhv_pkg::hdr_rec_t  head_rec,
  output logic               pop,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [3:0]         out_status,
  output logic [31:0]        out_payload_length,
  output logic [31:0]        out_payload_checksum,
  output logic [31:0]        out_target_version,
  output logic [63:0]        out_nonce_upper,
  output logic [63:0]        out_nonce_lower
);

  logic            valid_r, valid_nxt;
  uhv_pkg::status_t st;
  logic [31:0]     limit;
  logic [31:0]     total;
  logic            len_bad;
  logic [3:0]      status_r;
  logic [31:0]     plen_r, pcrc_r, tver_r;
  logic [63:0]     nup_r, nlo_r;

  assign limit = (cfg.max_package_bytes >= uhv_pkg::HDR_LEN32) ?
                 (cfg.max_package_bytes - uhv_pkg::HDR_LEN32) : 32'd0;
  assign total = uhv_pkg::HDR_LEN32 + head_rec.payload_length;
  assign len_bad = (head_rec.payload_length == 32'd0) ||
                   (head_rec.payload_length > limit) ||
                   (head_rec.package_bytes != total);

  always_comb begin
    if (!head_rec.magic_ok)                              st = uhv_pkg::ST_MAGIC;
    else if (!head_rec.hdrlen_ok)                        st = uhv_pkg::ST_HDRLEN;
    else if (!head_rec.crc_ok)                           st = uhv_pkg::ST_HDRCRC;
    else if (head_rec.flags != cfg.required_flags)       st = uhv_pkg::ST_FLAGS;
    else if (!head_rec.algo_ok)                          st = uhv_pkg::ST_ALGO;
    else if (!head_rec.key_ok)                           st = uhv_pkg::ST_KEY;
    else if (head_rec.hw_rev != cfg.hardware_revision)   st = uhv_pkg::ST_HW;
    else if (head_rec.layout != cfg.layout_code)         st = uhv_pkg::ST_LAYOUT;
    else if (head_rec.req_boot > cfg.boot_level)         st = uhv_pkg::ST_BOOT;
    else if (head_rec.target_version <= cfg.running_version) st = uhv_pkg::ST_VERSION;
    else if (!head_rec.base_ok)                          st = uhv_pkg::ST_BASE;
    else if (len_bad)                                    st = uhv_pkg::ST_LENGTH;
    else                                                 st = uhv_pkg::ST_OK;
  end

  // output register refills in the cycle it is taken
  assign pop = head_valid && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status_r <= st;
      if (st == uhv_pkg::ST_OK) begin
        plen_r <= head_rec.payload_length;
        pcrc_r <= head_rec.payload_checksum;
        tver_r <= head_rec.target_version;
        nup_r  <= head_rec.nonce_upper;
        nlo_r  <= head_rec.nonce_lower;
      end else begin
        plen_r <= '0;
        pcrc_r <= '0;
        tver_r <= '0;
        nup_r  <= '0;
        nlo_r  <= '0;
      end
    end
  end

  assign out_valid            = valid_r;
  assign out_status           = status_r;
  assign out_payload_length   = plen_r;
  assign out_payload_checksum = pcrc_r;
  assign out_target_version   = tver_r;
  assign out_nonce_upper      = nup_r;
  assign out_nonce_lower      = nlo_r;

endmodule

[src/update_header_validator_unit.sv]
// Update package header validator.
// Input channel (in_valid / in_stall): one header byte per transaction, offsets
// 0 to 63 in order; in_first_byte forces offset 0 and restarts capture and CRC.
// in_package_bytes is sampled only with the byte at offset 63.
// Output channel (out_valid / out_stall): one transaction per header, with the
// status code and, when the status is ok, the payload length, payload CRC,
// target version and the two nonce words (all zero on an error status).
// Config port (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready;
// write only while no header is in flight.
// Throughput: one byte per cycle while in_stall is low; the bytewise CRC and the
// capture shift line take one byte each cycle. The result for a header passes
// through the queue register, then the output register, after offset 63 is taken.
// Up to two finished headers wait in the queue while the receiver stalls; the
// input stalls only when that queue is full.
// Reset (synchronous, rst_n low) returns to offset 0, CRC all ones, queue and
// output empty, registers to their defaults (max package 1 MiB, others 0).
module update_header_validator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_header_byte,
  input  logic        in_first_byte,
  input  logic [31:0] in_package_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [31:0] out_payload_length,
  output logic [31:0] out_payload_checksum,
  output logic [31:0] out_target_version,
  output logic [63:0] out_nonce_upper,
  output logic [63:0] out_nonce_lower,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  uhv_pkg::cfg_t     cfg_r, cfg_nxt;
  uhv_pkg::hdr_rec_t push_rec, head_rec;
  uhv_pkg::q_stat_t  q_stat;
  logic              accept, push, pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (uhv_pkg::cfg_idx_t'(cfg_index))
        uhv_pkg::REG_HW_REV:   cfg_nxt.hardware_revision = cfg_data[15:0];
        uhv_pkg::REG_LAYOUT:   cfg_nxt.layout_code       = cfg_data[7:0];
        uhv_pkg::REG_BOOT:     cfg_nxt.boot_level        = cfg_data[7:0];
        uhv_pkg::REG_RUN_VER:  cfg_nxt.running_version   = cfg_data;
        uhv_pkg::REG_REQ_FLAG: cfg_nxt.required_flags    = cfg_data[15:0];
        uhv_pkg::REG_MAX_PKG:  cfg_nxt.max_package_bytes = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= uhv_pkg::CFG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  uhv_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .header_byte   (in_header_byte),
    .first_byte    (in_first_byte),
    .package_bytes (in_package_bytes),
    .push          (push),
    .rec           (push_rec)
  );

  uhv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .stat     (q_stat)
  );

  uhv_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .head_valid           (!q_stat.empty),
    .head_rec             (head_rec),
    .pop                  (pop),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_payload_length   (out_payload_length),
    .out_payload_checksum (out_payload_checksum),
    .out_target_version   (out_target_version),
    .out_nonce_upper      (out_nonce_upper),
    .out_nonce_lower      (out_nonce_lower)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("header pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != uhv_pkg::ST_OK) |->
      (out_payload_length == 32'd0 && out_target_version == 32'd0 &&
       out_nonce_upper == 64'd0 && out_nonce_lower == 64'd0))
    else $error("error result carries nonzero fields");

  a_stall_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status) && !pop ||
                                  out_valid && $stable(out_status)))
    else $error("stalled result lost or changed");

endmodule

[sim/testbench.sv]
module testbench;

  // header field offsets
  localparam int OffHdrLen = 4;
  localparam int OffFlags  = 6;
  localparam int OffAlgo   = 8;
  localparam int OffKey    = 12;
  localparam int OffNonce  = 16;
  localparam int OffPlen   = 32;
  localparam int OffPcrc   = 36;
  localparam int OffTver   = 40;
  localparam int OffBase   = 44;
  localparam int OffHw     = 48;
  localparam int OffLayout = 50;
  localparam int OffBoot   = 51;
  localparam int OffPad    = 52;
  localparam int OffCrc    = 60;

  localparam logic [31:0] AlgoId = 32'd1;
  localparam logic [31:0] KeyId  = 32'd1;

  localparam int FirstRand  = 0;
  localparam int FirstSet   = 1;
  localparam int FirstClear = 2;

  localparam int  LatencyPad    = 4;
  localparam int  PrintCap      = 100;
  localparam longint LimitCycles = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_header_byte = '0;
  logic        in_first_byte = 1'b0;
  logic [31:0] in_package_bytes = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_status;
  logic [31:0] out_payload_length;
  logic [31:0] out_payload_checksum;
  logic [31:0] out_target_version;
  logic [63:0] out_nonce_upper;
  logic [63:0] out_nonce_lower;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  update_header_validator_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_header_byte      (in_header_byte),
    .in_first_byte       (in_first_byte),
    .in_package_bytes    (in_package_bytes),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_payload_length  (out_payload_length),
    .out_payload_checksum(out_payload_checksum),
    .out_target_version  (out_target_version),
    .out_nonce_upper     (out_nonce_upper),
    .out_nonce_lower     (out_nonce_lower),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  typedef struct {
    uhv_pkg::status_t status;
    logic [31:0]      plen;
    logic [31:0]      pcrc;
    logic [31:0]      tver;
    logic [63:0]      nonce_hi;
    logic [63:0]      nonce_lo;
  } verdict_t;

  // validator mirror
  uhv_pkg::cfg_t cfg_m;
  logic [7:0]    hdr_mem [uhv_pkg::HdrBytes];
  logic [5:0]    hdr_pos;
  logic [31:0]   crc_run;
  verdict_t      verdicts_due [$];

  // header under construction
  logic [7:0]  pkt [uhv_pkg::HdrBytes];
  logic [31:0] pkt_total;

  int mismatches = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_left = 0;

  always #10 clk = ~clk;

  initial begin
    #(LimitCycles * 20);
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ uhv_pkg::CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic logic [63:0] stored_le(input int off, input int nbytes);
    logic [63:0] acc;
    acc = '0;
    for (int k = nbytes - 1; k >= 0; k--) acc = {acc[55:0], hdr_mem[off + k]};
    return acc;
  endfunction

  function automatic uhv_pkg::status_t judge_header(input logic [31:0] pkg);
    logic [31:0] plen;
    logic [31:0] room;
    if (stored_le(0, 4) != 64'(uhv_pkg::MAGIC)) return uhv_pkg::ST_MAGIC;
    if (stored_le(OffHdrLen, 2) != 64'(uhv_pkg::HdrBytes)) return uhv_pkg::ST_HDRLEN;
    if (~crc_run != 32'(stored_le(OffCrc, 4))) return uhv_pkg::ST_HDRCRC;
    if (stored_le(OffFlags, 2) != 64'(cfg_m.required_flags)) return uhv_pkg::ST_FLAGS;
    if (stored_le(OffAlgo, 4) != 64'(AlgoId)) return uhv_pkg::ST_ALGO;
    if (stored_le(OffKey, 4) != 64'(KeyId)) return uhv_pkg::ST_KEY;
    if (stored_le(OffHw, 2) != 64'(cfg_m.hardware_revision)) return uhv_pkg::ST_HW;
    if (hdr_mem[OffLayout] != cfg_m.layout_code) return uhv_pkg::ST_LAYOUT;
    if (hdr_mem[OffBoot] > cfg_m.boot_level) return uhv_pkg::ST_BOOT;
    if (32'(stored_le(OffTver, 4)) <= cfg_m.running_version) return uhv_pkg::ST_VERSION;
    if (stored_le(OffBase, 4) != 64'd0) return uhv_pkg::ST_BASE;
    for (int k = OffPad; k < uhv_pkg::CrcSpan; k++)
      if (hdr_mem[k] != 8'd0) return uhv_pkg::ST_BASE;
    plen = 32'(stored_le(OffPlen, 4));
    room = (cfg_m.max_package_bytes >= uhv_pkg::HDR_LEN32) ?
           cfg_m.max_package_bytes - uhv_pkg::HDR_LEN32 : 32'd0;
    if (plen == 32'd0 || plen > room || pkg != uhv_pkg::HDR_LEN32 + plen)
      return uhv_pkg::ST_LENGTH;
    return uhv_pkg::ST_OK;
  endfunction

  // returns 1 when this byte completes a header
  function automatic bit absorb_byte(input logic [7:0] b, input logic mark_first,
                                     input logic [31:0] pkg, output verdict_t v);
    if (mark_first) hdr_pos = '0;
    if (hdr_pos == 6'd0) crc_run = uhv_pkg::CRC_INIT;
    hdr_mem[hdr_pos] = b;
    if (hdr_pos < 6'(uhv_pkg::CrcSpan)) crc_run = crc_step(crc_run, b);
    if (hdr_pos != 6'(uhv_pkg::HdrBytes - 1)) begin
      hdr_pos = hdr_pos + 6'd1;
      return 1'b0;
    end
    v.status = judge_header(pkg);
    if (v.status == uhv_pkg::ST_OK) begin
      v.plen     = 32'(stored_le(OffPlen, 4));
      v.pcrc     = 32'(stored_le(OffPcrc, 4));
      v.tver     = 32'(stored_le(OffTver, 4));
      v.nonce_hi = stored_le(OffNonce, 8);
      v.nonce_lo = stored_le(OffNonce + 8, 8);
    end else begin
      v.plen     = '0;
      v.pcrc     = '0;
      v.tver     = '0;
      v.nonce_hi = '0;
      v.nonce_lo = '0;
    end
    hdr_pos = '0;
    crc_run = uhv_pkg::CRC_INIT;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    if (mismatches <= PrintCap)
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
  endtask

  always @(posedge clk) begin : check_result
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        flag_mismatch("unexpected header result", 64'(out_status), '0);
      end else begin
        want = verdicts_due.pop_front();
        if (out_status !== want.status)
          flag_mismatch("status", 64'(out_status), 64'(want.status));
        if (out_payload_length !== want.plen)
          flag_mismatch("payload_length", 64'(out_payload_length), 64'(want.plen));
        if (out_payload_checksum !== want.pcrc)
          flag_mismatch("payload_checksum", 64'(out_payload_checksum), 64'(want.pcrc));
        if (out_target_version !== want.tver)
          flag_mismatch("target_version", 64'(out_target_version), 64'(want.tver));
        if (out_nonce_upper !== want.nonce_hi)
          flag_mismatch("nonce_upper", out_nonce_upper, want.nonce_hi);
        if (out_nonce_lower !== want.nonce_lo)
          flag_mismatch("nonce_lower", out_nonce_lower, want.nonce_lo);
      end
    end
  end

  // valid stays high across back-to-back transactions; lowered only for a gap
  task automatic send_byte(input logic [7:0] b, input logic mark_first, input logic [31:0] pkg);
    verdict_t v;
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid         <= 1'b1;
    in_header_byte   <= b;
    in_first_byte    <= mark_first;
    in_package_bytes <= pkg;
    do @(posedge clk); while (in_stall);
    if (absorb_byte(b, mark_first, pkg, v)) verdicts_due.push_back(v);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (verdicts_due.size() != 0);
  endtask

  // finish any partial header, then let the block go quiet
  task automatic settle();
    while (hdr_pos != 6'd0) send_byte(8'($urandom), 1'b0, $urandom);
    wait_drain();
    repeat (LatencyPad) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (uhv_pkg::cfg_idx_t'(idx))
      uhv_pkg::REG_HW_REV:   cfg_m.hardware_revision = data[15:0];
      uhv_pkg::REG_LAYOUT:   cfg_m.layout_code       = data[7:0];
      uhv_pkg::REG_BOOT:     cfg_m.boot_level        = data[7:0];
      uhv_pkg::REG_RUN_VER:  cfg_m.running_version   = data;
      uhv_pkg::REG_REQ_FLAG: cfg_m.required_flags    = data[15:0];
      uhv_pkg::REG_MAX_PKG:  cfg_m.max_package_bytes = data;
      default: ;
    endcase
  endtask

  // junk in the unused upper bits checks that narrow registers mask them off
  task automatic program_regs(input uhv_pkg::cfg_t c);
    settle();
    cfg_write(uhv_pkg::REG_HW_REV,   {16'($urandom), c.hardware_revision});
    cfg_write(uhv_pkg::REG_LAYOUT,   {24'($urandom), c.layout_code});
    cfg_write(uhv_pkg::REG_BOOT,     {24'($urandom), c.boot_level});
    cfg_write(uhv_pkg::REG_RUN_VER,  c.running_version);
    cfg_write(uhv_pkg::REG_REQ_FLAG, {16'($urandom), c.required_flags});
    cfg_write(uhv_pkg::REG_MAX_PKG,  c.max_package_bytes);
    for (int k = int'(uhv_pkg::REG_MAX_PKG) + 1; k < (1 << uhv_pkg::CfgIdxW); k++)
      cfg_write(k[uhv_pkg::CfgIdxW-1:0], $urandom);
    cfg_valid <= 1'b0;
  endtask

  function automatic uhv_pkg::cfg_t random_cfg();
    uhv_pkg::cfg_t c;
    c.hardware_revision = 16'($urandom);
    c.layout_code       = 8'($urandom);
    c.boot_level        = 8'($urandom);
    c.required_flags    = 16'($urandom);
    c.running_version   = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h00FF_FFFF);
    c.max_package_bytes = ($urandom_range(3) == 0) ? $urandom :
                          $urandom_range(32'h0400_0000, uhv_pkg::HDR_LEN32 + 32'd1);
    return c;
  endfunction

  function automatic void put_le(input int off, input int nbytes, input logic [63:0] val);
    for (int k = 0; k < nbytes; k++) pkt[off + k] = val[8*k +: 8];
  endfunction

  function automatic logic [7:0] nonzero_byte();
    return 8'($urandom_range(255, 1));
  endfunction

  function automatic logic [31:0] payload_room();
    return (cfg_m.max_package_bytes >= uhv_pkg::HDR_LEN32) ?
           cfg_m.max_package_bytes - uhv_pkg::HDR_LEN32 : 32'd0;
  endfunction

  function automatic void seal_crc(input bit spoil);
    logic [31:0] crc;
    crc = uhv_pkg::CRC_INIT;
    for (int k = 0; k < uhv_pkg::CrcSpan; k++) crc = crc_step(crc, pkt[k]);
    put_le(OffCrc, 4, 64'(~crc));
    if (spoil) pkt[OffCrc + $urandom_range(3)] ^= nonzero_byte();
  endfunction

  // well-formed header for the current registers, then the requested fault, if any, injected
  function automatic void build_header(input uhv_pkg::status_t fault);
    logic [31:0] room;
    logic [31:0] plen;
    logic [31:0] tver;
    room = payload_room();
    if (room == 32'd0) plen = 32'd1;
    else case ($urandom_range(3))
      0:       plen = room;
      1:       plen = $urandom_range(room, 1);
      default: plen = $urandom_range((room < 32'd4096) ? room : 32'd4096, 1);
    endcase
    if (cfg_m.running_version == 32'hFFFF_FFFF) tver = $urandom;
    else if ($urandom_range(3) == 0) tver = cfg_m.running_version + 32'd1;
    else tver = $urandom_range(32'hFFFF_FFFF, cfg_m.running_version + 32'd1);
    put_le(0, 4, 64'(uhv_pkg::MAGIC));
    put_le(OffHdrLen, 2, 64'(uhv_pkg::HdrBytes));
    put_le(OffFlags, 2, 64'(cfg_m.required_flags));
    put_le(OffAlgo, 4, 64'(AlgoId));
    put_le(OffKey, 4, 64'(KeyId));
    for (int k = OffNonce; k < OffPlen; k++) pkt[k] = 8'($urandom);
    put_le(OffPlen, 4, 64'(plen));
    put_le(OffPcrc, 4, 64'($urandom));
    put_le(OffTver, 4, 64'(tver));
    put_le(OffBase, 4, 64'd0);
    put_le(OffHw, 2, 64'(cfg_m.hardware_revision));
    pkt[OffLayout] = cfg_m.layout_code;
    pkt[OffBoot]   = 8'($urandom_range(cfg_m.boot_level, 0));
    for (int k = OffPad; k < uhv_pkg::CrcSpan; k++) pkt[k] = 8'd0;
    pkt_total = uhv_pkg::HDR_LEN32 + plen;
    case (fault)
      uhv_pkg::ST_MAGIC:   pkt[$urandom_range(3)] ^= nonzero_byte();
      uhv_pkg::ST_HDRLEN:  pkt[OffHdrLen + $urandom_range(1)] ^= nonzero_byte();
      uhv_pkg::ST_FLAGS:   pkt[OffFlags + $urandom_range(1)] ^= nonzero_byte();
      uhv_pkg::ST_ALGO:    pkt[OffAlgo + $urandom_range(3)] ^= nonzero_byte();
      uhv_pkg::ST_KEY:     pkt[OffKey + $urandom_range(3)] ^= nonzero_byte();
      uhv_pkg::ST_HW:      pkt[OffHw + $urandom_range(1)] ^= nonzero_byte();
      uhv_pkg::ST_LAYOUT:  pkt[OffLayout] ^= nonzero_byte();
      uhv_pkg::ST_BOOT:    if (cfg_m.boot_level != 8'hFF)
                             pkt[OffBoot] = 8'($urandom_range(255, cfg_m.boot_level + 8'd1));
      uhv_pkg::ST_VERSION: put_le(OffTver, 4, 64'($urandom_range(cfg_m.running_version, 0)));
      uhv_pkg::ST_BASE:    if ($urandom_range(1) == 0)
                             pkt[OffBase + $urandom_range(3)] = nonzero_byte();
                           else
                             pkt[$urandom_range(uhv_pkg::CrcSpan - 1, OffPad)] = nonzero_byte();
      uhv_pkg::ST_LENGTH:  case ($urandom_range(2))
                             0: begin
                               put_le(OffPlen, 4, 64'd0);
                               pkt_total = uhv_pkg::HDR_LEN32;
                             end
                             1: begin
                               put_le(OffPlen, 4, 64'(room + 32'd1));
                               pkt_total = uhv_pkg::HDR_LEN32 + room + 32'd1;
                             end
                             default: pkt_total ^= 32'd1 << $urandom_range(31);
                           endcase
      default: ;
    endcase
    seal_crc(fault == uhv_pkg::ST_HDRCRC);
  endfunction

  function automatic uhv_pkg::status_t pick_fault();
    int r;
    r = int'($urandom_range(23));
    return (r > int'(uhv_pkg::ST_LENGTH)) ? uhv_pkg::ST_OK : uhv_pkg::status_t'(r);
  endfunction

  // send the first upto bytes of pkt; a restart is forced when mid-header
  task automatic send_frame(input int upto, input int first_mode);
    logic mark;
    mark = (hdr_pos != 6'd0) || (first_mode == FirstSet) ||
           (first_mode == FirstRand && $urandom_range(1) == 1);
    for (int k = 0; k < upto; k++)
      send_byte(pkt[k], (k == 0) && mark,
                (k == uhv_pkg::HdrBytes - 1) ? pkt_total : $urandom);
  endtask

  task automatic run_header(input uhv_pkg::status_t fault);
    build_header(fault);
    send_frame(uhv_pkg::HdrBytes, FirstRand);
  endtask

  task automatic random_traffic(input int headers);
    for (int n = 0; n < headers; n++) begin
      case ($urandom_range(9))
        0: repeat ($urandom_range(80, 1))
             send_byte(8'($urandom), $urandom_range(15) == 0, $urandom);
        1: begin
          // abandoned header, then a fresh one restarts capture
          build_header(pick_fault());
          send_frame(int'($urandom_range(uhv_pkg::HdrBytes - 1, 1)), FirstRand);
          run_header(pick_fault());
        end
        default: run_header(pick_fault());
      endcase
    end
  endtask

  task automatic test_directed();
    build_header(uhv_pkg::ST_OK);
    for (int k = OffNonce; k < OffPlen; k++) pkt[k] = 8'hFF;
    seal_crc(1'b0);
    send_frame(uhv_pkg::HdrBytes, FirstSet);
    // offset zero reached by wrap, no first-byte mark
    build_header(uhv_pkg::ST_OK);
    for (int k = OffNonce; k < OffPlen; k++) pkt[k] = 8'h00;
    put_le(OffPcrc, 4, 64'hFFFF_FFFF);
    seal_crc(1'b0);
    send_frame(uhv_pkg::HdrBytes, FirstClear);
    build_header(uhv_pkg::ST_OK);
    send_frame(23, FirstSet);
    build_header(uhv_pkg::ST_OK);
    send_frame(uhv_pkg::HdrBytes, FirstSet);
    build_header(uhv_pkg::ST_MAGIC);
    pkt[0] = ~pkt[0];
    seal_crc(1'b0);
    send_frame(uhv_pkg::HdrBytes, FirstRand);
    run_header(uhv_pkg::ST_LENGTH);
    run_header(uhv_pkg::ST_HDRCRC);
  endtask

  task automatic test_register_extremes();
    uhv_pkg::cfg_t c;
    c = '{16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFE, 16'hFFFF, 32'hFFFF_FFFF};
    program_regs(c);
    // largest payload: package length lands exactly on all ones
    build_header(uhv_pkg::ST_OK);
    put_le(OffPlen, 4, 64'(payload_room()));
    pkt_total = uhv_pkg::HDR_LEN32 + payload_room();
    seal_crc(1'b0);
    send_frame(uhv_pkg::HdrBytes, FirstRand);
    run_header(pick_fault());
    c = '{16'h0000, 8'h00, 8'h00, 32'h0000_0000, 16'h0000, uhv_pkg::HDR_LEN32 + 32'd1};
    program_regs(c);
    run_header(uhv_pkg::ST_OK);
    run_header(uhv_pkg::ST_BOOT);
    c.max_package_bytes = uhv_pkg::HDR_LEN32;
    program_regs(c);
    run_header(uhv_pkg::ST_OK);
    c.max_package_bytes = uhv_pkg::HDR_LEN32 - 32'd1;
    program_regs(c);
    run_header(uhv_pkg::ST_OK);
    c.max_package_bytes = '0;
    c.running_version   = 32'hFFFF_FFFF;
    program_regs(c);
    run_header(uhv_pkg::ST_OK);
    c = random_cfg();
    c.max_package_bytes = uhv_pkg::MAX_PKG_RST;
    program_regs(c);
    run_header(pick_fault());
  endtask

  task automatic traffic_phase(input int sender_gap, input int receiver_gap);
    send_idle  = sender_gap;
    recv_stall = receiver_gap;
    repeat (2) begin
      program_regs(random_cfg());
      random_traffic(1);
    end
  endtask

  task automatic test_random_traffic();
    traffic_phase(0, 0);
    traffic_phase(46, 0);
    traffic_phase(0, 46);
    traffic_phase(20, 20);
  endtask

  // receiver blocks long enough for the result queue to fill and stall input
  task automatic test_output_holdoff();
    send_idle  = 0;
    recv_stall = 0;
    settle();
    hold_left = 600;
    repeat (4) run_header(pick_fault());
  endtask

  task automatic test_paused_sender();
    send_idle  = 20;
    recv_stall = 46;
    repeat (2) begin
      run_header(pick_fault());
      wait_drain();
    end
  endtask

  initial begin
    cfg_m = uhv_pkg::CFG_RST;
    hdr_pos = '0;
    crc_run = uhv_pkg::CRC_INIT;
    for (int k = 0; k < uhv_pkg::HdrBytes; k++) hdr_mem[k] = 8'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_register_extremes();
    test_random_traffic();
    test_output_holdoff();
    test_paused_sender();
    wait_drain();
    repeat (LatencyPad) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/uhv_pkg.sv
src/uhv_front.sv
src/uhv_queue.sv
src/uhv_back.sv
src/update_header_validator_unit.sv
sim/testbench.sv
